### rtl/traffic_stream_table_top_assert.svh
// Assertion macros for the traffic stream table.
`ifndef TRAFFIC_STREAM_TABLE_TOP_ASSERT_SVH
`define TRAFFIC_STREAM_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TST_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
`define TST_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define TST_ASSERT_SAME(label, clk, rst_n, pre, post, msg)
`define TST_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

### rtl/tst_pkg.sv
// Shared types, codes and the priority-to-class map of the traffic stream table.
`timescale 1ns / 1ps
`default_nettype none
package tst_pkg;

  typedef enum logic [2:0] {
    CMD_UPDATE      = 3'd0,
    CMD_REMOVE      = 3'd1,
    CMD_QUERY_TID   = 3'd2,
    CMD_QUERY_CLASS = 3'd3,
    CMD_SET_STATUS  = 3'd4,
    CMD_FREE_TID    = 3'd5,
    CMD_REPORT      = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  localparam logic [1:0] DIR_BIDIR = 2'd2;
  localparam int NUM_PRIO  = 8;
  localparam int NUM_CLASS = 4;
  localparam int NUM_SUMS  = NUM_PRIO + NUM_CLASS;
  localparam logic [3:0] SUM_CLASS_BASE = 4'(NUM_PRIO);
  localparam logic [3:0] SUM_LAST       = 4'(NUM_SUMS - 1);

  function automatic logic [1:0] prio_to_class(input logic [2:0] prio);
    logic [1:0] cls;
    case (prio)
      3'd0, 3'd3: cls = 2'd0;
      3'd1, 3'd2: cls = 2'd1;
      3'd4, 3'd5: cls = 2'd2;
      default:    cls = 2'd3;
    endcase
    return cls;
  endfunction

endpackage
`default_nettype wire

### rtl/traffic_stream_table_top.sv
// Traffic stream table: per-TID stream slots, queries and medium-time report.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+--------------------------------
//  request  | start, busy, in_*                       | taken when start & !busy
//  result   | out_valid, out_*                        | registered, no stall
//
// Per request (N = TID_SLOTS): update, remove, query tid and unknown
// codes finish in the accept cycle. Query class and set status stay busy
// while they walk all N slots; free tid stops at the first free slot. The report
// walks each slot twice through one 16-bit adder (priority, then class sum),
// then shows its 12 sums one per cycle. Results are registered and appear in
// the cycle after the one that forms them; the receiver cannot stall.
// Reset (synchronous, rst_n low) clears the valid bits and the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module traffic_stream_table_top #(
  parameter int TID_SLOTS = 8
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire  [2:0]  in_command,
  input  wire  [2:0]  in_tid,
  input  wire  [2:0]  in_prio,
  input  wire  [1:0]  in_direction,
  input  wire  [15:0] in_airtime,
  input  wire  [1:0]  in_tclass,
  input  wire  [2:0]  in_status,
  output logic        out_valid,
  output logic        out_found,
  output logic [3:0]  out_free_tid,
  output logic        out_sum_kind,
  output logic [2:0]  out_sum_index,
  output logic [15:0] out_time_sum,
  output logic        out_last
);

  localparam int SLOT_W = (TID_SLOTS > 1) ? $clog2(TID_SLOTS) : 1;
  localparam int CNT_W  = SLOT_W + 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TID_SLOTS - 1);
  localparam logic [4:0] SLOT_COUNT = 5'(TID_SLOTS);
  localparam logic [3:0] FULL_TID   = 4'(TID_SLOTS);

  // Slot storage: valid bits reset, fields hold whatever was last written.
  logic              valid_r [TID_SLOTS];
  logic [2:0]        prio_r  [TID_SLOTS];
  logic [1:0]        dir_r   [TID_SLOTS];
  logic [15:0]       time_r  [TID_SLOTS];
  logic [1:0]        cls_r   [TID_SLOTS];
  logic [2:0]        stat_r  [TID_SLOTS];

  // Report accumulators: eight priority sums, then four class sums.
  logic [15:0]       sum_r [tst_pkg::NUM_SUMS];

  // Sequencer.
  tst_pkg::state_t   state_r, state_nxt;
  tst_pkg::cmd_t     cmd_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [3:0]        emit_r, emit_nxt;
  logic              hit_r, hit_nxt;
  logic [1:0]        ac_r;
  logic [2:0]        st_r;

  // Registered result.
  logic              out_valid_r, out_valid_nxt;
  logic              found_r, found_nxt;
  logic [3:0]        ftid_r, ftid_nxt;
  logic              kind_r, kind_nxt;
  logic [2:0]        idx_r, idx_nxt;
  logic [15:0]       tsum_r, tsum_nxt;
  logic              last_r, last_nxt;

  logic              accept;
  logic              tid_ok;
  logic [SLOT_W-1:0] tid_idx;
  logic [SLOT_W-1:0] scan_slot;
  logic              phase;
  logic              walk_end;
  logic              hit_w;
  logic [15:0]       addend;
  logic [3:0]        sum_addr;
  logic              walk_add;

  assign accept  = start && (state_r == tst_pkg::ST_IDLE);
  assign busy    = (state_r != tst_pkg::ST_IDLE);
  assign tid_ok  = ({2'b00, in_tid} < SLOT_COUNT);
  assign tid_idx = SLOT_W'(in_tid);

  // The report visits each slot twice: low count bit picks priority or class.
  assign scan_slot = (cmd_r == tst_pkg::CMD_REPORT) ? cnt_r[CNT_W-1:1] : cnt_r[SLOT_W-1:0];
  assign phase     = cnt_r[0];
  assign walk_end  = (scan_slot == LAST_SLOT) && ((cmd_r != tst_pkg::CMD_REPORT) || phase);
  assign hit_w     = hit_r || (valid_r[scan_slot] &&
                     (tst_pkg::prio_to_class(prio_r[scan_slot]) == ac_r));

  // Shared adder operand: a bidirectional stream counts twice.
  assign addend   = (dir_r[scan_slot] == tst_pkg::DIR_BIDIR) ?
                    {time_r[scan_slot][14:0], 1'b0} : time_r[scan_slot];
  assign sum_addr = phase ? (tst_pkg::SUM_CLASS_BASE + {2'b00, cls_r[scan_slot]})
                          : {1'b0, prio_r[scan_slot]};
  assign walk_add = (state_r == tst_pkg::ST_WALK) && (cmd_r == tst_pkg::CMD_REPORT) &&
                    valid_r[scan_slot];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    emit_nxt      = emit_r;
    hit_nxt       = hit_r;
    out_valid_nxt = 1'b0;
    found_nxt     = 1'b0;
    ftid_nxt      = 4'd0;
    kind_nxt      = 1'b0;
    idx_nxt       = 3'd0;
    tsum_nxt      = 16'd0;
    last_nxt      = 1'b0;
    unique case (state_r)
      tst_pkg::ST_IDLE: begin
        if (start) begin
          cnt_nxt  = '0;
          emit_nxt = 4'd0;
          hit_nxt  = 1'b0;
          case (tst_pkg::cmd_t'(in_command)) inside
            tst_pkg::CMD_QUERY_TID: begin
              out_valid_nxt = 1'b1;
              found_nxt     = tid_ok && valid_r[tid_idx];
              last_nxt      = 1'b1;
            end
            tst_pkg::CMD_QUERY_CLASS, tst_pkg::CMD_SET_STATUS,
            tst_pkg::CMD_FREE_TID, tst_pkg::CMD_REPORT: begin
              state_nxt = tst_pkg::ST_WALK;
            end
            default: begin
            end
          endcase
        end
      end
      tst_pkg::ST_WALK: begin
        cnt_nxt = cnt_r + 1'b1;
        case (cmd_r)
          tst_pkg::CMD_QUERY_CLASS: begin
            hit_nxt = hit_w;
            if (walk_end) begin
              out_valid_nxt = 1'b1;
              found_nxt     = hit_w;
              last_nxt      = 1'b1;
              state_nxt     = tst_pkg::ST_IDLE;
            end
          end
          tst_pkg::CMD_FREE_TID: begin
            // Stop at the first free slot.
            if (!valid_r[scan_slot] || walk_end) begin
              out_valid_nxt = 1'b1;
              ftid_nxt      = valid_r[scan_slot] ? FULL_TID : 4'(scan_slot);
              last_nxt      = 1'b1;
              state_nxt     = tst_pkg::ST_IDLE;
            end
          end
          tst_pkg::CMD_SET_STATUS: begin
            if (walk_end) begin
              state_nxt = tst_pkg::ST_IDLE;
            end
          end
          tst_pkg::CMD_REPORT: begin
            if (walk_end) begin
              emit_nxt  = 4'd0;
              state_nxt = tst_pkg::ST_EMIT;
            end
          end
          default: begin
            state_nxt = tst_pkg::ST_IDLE;
          end
        endcase
      end
      tst_pkg::ST_EMIT: begin
        out_valid_nxt = 1'b1;
        kind_nxt      = (emit_r >= tst_pkg::SUM_CLASS_BASE);
        idx_nxt       = emit_r[2:0];
        tsum_nxt      = sum_r[emit_r];
        last_nxt      = (emit_r == tst_pkg::SUM_LAST);
        emit_nxt      = emit_r + 4'd1;
        if (emit_r == tst_pkg::SUM_LAST) begin
          state_nxt = tst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tst_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tst_pkg::ST_IDLE;
      cmd_r       <= tst_pkg::CMD_UPDATE;
      cnt_r       <= '0;
      emit_r      <= 4'd0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      emit_r      <= emit_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        cmd_r <= tst_pkg::cmd_t'(in_command);
      end
    end
  end

  // Request operands and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      ac_r <= in_tclass;
      st_r <= in_status;
    end
    found_r <= found_nxt;
    ftid_r  <= ftid_nxt;
    kind_r  <= kind_nxt;
    idx_r   <= idx_nxt;
    tsum_r  <= tsum_nxt;
    last_r  <= last_nxt;
  end

  // Valid bits: set on update, drop on remove.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TID_SLOTS; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (accept && tid_ok) begin
      if (in_command == tst_pkg::CMD_UPDATE) begin
        valid_r[tid_idx] <= 1'b1;
      end else if (in_command == tst_pkg::CMD_REMOVE) begin
        valid_r[tid_idx] <= 1'b0;
      end
    end
  end

  // Slot fields: written whole on update, status rewritten by the walk.
  always_ff @(posedge clk) begin
    if (accept && tid_ok && (in_command == tst_pkg::CMD_UPDATE)) begin
      prio_r[tid_idx] <= in_prio;
      dir_r[tid_idx]  <= in_direction;
      time_r[tid_idx] <= in_airtime;
      cls_r[tid_idx]  <= in_tclass;
      stat_r[tid_idx] <= in_status;
    end else if ((state_r == tst_pkg::ST_WALK) && (cmd_r == tst_pkg::CMD_SET_STATUS) &&
                 valid_r[scan_slot]) begin
      stat_r[scan_slot] <= st_r;
    end
  end

  // Report accumulators through the shared adder.
  always_ff @(posedge clk) begin
    if (accept && (in_command == tst_pkg::CMD_REPORT)) begin
      for (int i = 0; i < tst_pkg::NUM_SUMS; i++) begin
        sum_r[i] <= 16'd0;
      end
    end else if (walk_add) begin
      sum_r[sum_addr] <= sum_r[sum_addr] + addend;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found     = found_r;
  assign out_free_tid  = ftid_r;
  assign out_sum_kind  = kind_r;
  assign out_sum_index = idx_r;
  assign out_time_sum  = tsum_r;
  assign out_last      = last_r;

`include "traffic_stream_table_top_assert.svh"

  // A report result that is not the last is followed at once by the next one.
  `TST_ASSERT_NEXT(a_report_burst, clk, rst_n, out_valid && !out_last, out_valid, "report burst broken")
  // Non-final results only come while the sequencer is still busy.
  `TST_ASSERT_SAME(a_busy_mid_burst, clk, rst_n, out_valid && !out_last, busy, "idle mid report")
  // Class sums carry class indexes only.
  `TST_ASSERT_SAME(a_class_index, clk, rst_n, out_valid && out_sum_kind, out_sum_index[2] == 1'b0, "class index out of range")
  // An accepted report keeps the block busy.
  `TST_ASSERT_NEXT(a_report_busy, clk, rst_n, start && !busy && (in_command == tst_pkg::CMD_REPORT), busy, "report not started")

endmodule
`default_nettype wire
